// ===== rtl/core/skt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes of the sorted key table
// Request and status codes, the sequencer state type and the fixed width
// of the position and entry count fields.
// ----------------------------------------------------------------------------
package skt_pkg;

   // Width of the position and entry count result fields
   localparam int FIELD_BITS = 11;

   // Request codes (code three is served as a lookup)
   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CHECK,
      ST_SHIFT,
      ST_PLACE,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/skt_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_req_if: request channel of the sorted key table
// Valid/ready channel carrying request type, key and value.
// ----------------------------------------------------------------------------
interface skt_req_if #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            req_type;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value_in;

   modport source (output valid, output req_type, output key, output value_in,
                   input ready);
   modport sink   (input valid, input req_type, input key, input value_in,
                   output ready);
endinterface

// ===== rtl/core/skt_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_rsp_if: response channel of the sorted key table
// Valid/ready channel carrying status, value, position and entry count.
// ----------------------------------------------------------------------------
interface skt_rsp_if
   import skt_pkg::*;
#(
   parameter int VALUE_BITS = 32
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [VALUE_BITS-1:0] value_out;
   logic [FIELD_BITS-1:0] position;
   logic [FIELD_BITS-1:0] entry_count;

   modport source (output valid, output status, output value_out,
                   output position, output entry_count, input ready);
   modport sink   (input valid, input status, input value_out,
                   input position, input entry_count, output ready);
endinterface

// ===== rtl/core/sorted_key_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_unit: sorted key/value table with binary search
// Entries kept in ascending signed key order in one single-port-read,
// single-port-write memory; insert and delete shift entries one per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one request (lookup, insert-or-replace, delete) per
//   valid/ready handshake; rsp_bus returns exactly one response per request,
//   in order. Request code three is served as a lookup.
//   Operation: each binary search probe is a memory read (PROBE) followed
//   by a compare (CHECK). A lookup, a miss or an insert into a full table
//   then goes to DONE, a replace through PLACE to DONE. An insert of a new
//   key moves every entry above the insertion point up by one, and a delete
//   moves them down, one entry per cycle through the memory read/write
//   pipeline. One request is in work at a time.
//   req_bus.ready is high while the sequencer is idle, also while a finished
//   response still waits in the output register. If rsp_bus.ready stays low,
//   the next request completes its work and then waits until the output
//   register is free.
//   Reset empties the table at once (entry count zero); memory contents are
//   not cleared since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_key_table_unit
   import skt_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   skt_req_if.sink   req_bus,
   skt_rsp_if.source rsp_bus
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = KEY_BITS + VALUE_BITS;

   // Entry memory: {key, value}
   logic [EW-1:0] mem [CAPACITY];
   logic          mem_we;
   logic          mem_re;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   logic [EW-1:0] mem_wdata;
   logic [EW-1:0] rd_data_ff;

   // Control state
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic          pend_ff, pend_in;
   logic          hit_ff, hit_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [1:0]            req_type_ff, req_type_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [VALUE_BITS-1:0] hit_value_ff, hit_value_in;
   logic [AW-1:0]         dst_ff, dst_in;
   logic [1:0]            status_ff, status_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [FIELD_BITS-1:0] rsp_position_ff, rsp_position_in;
   logic [FIELD_BITS-1:0] rsp_count_ff, rsp_count_in;

   // Datapath helpers
   logic [CW-1:0]         mid;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;
   logic                  is_insert;
   logic                  is_delete;
   logic                  search_done;
   logic                  shift_more;
   logic                  rsp_free;

   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_key     = rd_data_ff[EW-1 -: KEY_BITS];
   assign rd_value   = rd_data_ff[VALUE_BITS-1:0];
   assign is_insert  = (req_type_ff == REQ_INSERT);
   assign is_delete  = (req_type_ff == REQ_DELETE);
   assign search_done = (lo_ff >= hi_ff);
   assign shift_more = is_insert ? (cursor_ff > lo_ff) : (cursor_ff < count_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_bus.ready;

   // Memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (!search_done) begin
               state_in = ST_CHECK;
            end else if (is_insert) begin
               if (hit_ff) begin
                  state_in = ST_PLACE;
               end else if (count_ff == CW'(CAPACITY)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SHIFT;
               end
            end else if (is_delete && hit_ff) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CHECK: state_in = ST_PROBE;
         ST_SHIFT: begin
            if (!shift_more && !pend_ff) begin
               state_in = is_insert ? ST_PLACE : ST_DONE;
            end
         end
         ST_PLACE: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      mem_we          = 1'b0;
      mem_re          = 1'b0;
      mem_waddr       = dst_ff;
      mem_raddr       = mid[AW-1:0];
      mem_wdata       = rd_data_ff;
      req_bus.ready   = 1'b0;
      count_in        = count_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      cursor_in       = cursor_ff;
      pend_in         = pend_ff;
      hit_in          = hit_ff;
      hit_value_in    = hit_value_ff;
      dst_in          = dst_ff;
      status_in       = status_ff;
      req_type_in     = req_type_ff;
      key_in          = key_ff;
      value_in        = value_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;

      unique case (state_ff)
         // Take a request and open the search window over all entries
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               req_type_in = req_bus.req_type;
               key_in      = req_bus.key;
               value_in    = req_bus.value_in;
               lo_in       = '0;
               hi_in       = count_ff;
               hit_in      = 1'b0;
               status_in   = STATUS_DONE;
            end
         end
         // Issue a probe read, or decide once the window is closed
         ST_PROBE: begin
            if (!search_done) begin
               mem_re = 1'b1;
            end else if (is_insert) begin
               if (!hit_ff && count_ff == CW'(CAPACITY)) begin
                  status_in = STATUS_FULL;
               end else if (!hit_ff) begin
                  cursor_in = count_ff;
                  pend_in   = 1'b0;
               end
            end else if (is_delete && hit_ff) begin
               cursor_in = lo_ff + CW'(1);
               pend_in   = 1'b0;
            end else if (!hit_ff) begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         // Compare the probed key; a match anywhere means the key is present
         ST_CHECK: begin
            if ($signed(rd_key) < $signed(key_ff)) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
            if (rd_key == key_ff) begin
               hit_in       = 1'b1;
               hit_value_in = rd_value;
            end
         end
         // Move entries: read one ahead, write the one read last cycle
         ST_SHIFT: begin
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            pend_in = shift_more;
            if (shift_more) begin
               mem_re = 1'b1;
               if (is_insert) begin
                  mem_raddr = AW'(cursor_ff - CW'(1));
                  dst_in    = cursor_ff[AW-1:0];
                  cursor_in = cursor_ff - CW'(1);
               end else begin
                  mem_raddr = cursor_ff[AW-1:0];
                  dst_in    = AW'(cursor_ff - CW'(1));
                  cursor_in = cursor_ff + CW'(1);
               end
            end else if (!pend_ff && is_delete) begin
               count_in = count_ff - CW'(1);
            end
         end
         // Write the new or replaced entry at the search position
         ST_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = lo_ff[AW-1:0];
            mem_wdata = {key_ff, value_ff};
            if (!hit_ff) begin
               count_in = count_ff + CW'(1);
            end
         end
         // Hand the result to the output register
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_value_in    = (!is_insert && !is_delete && hit_ff) ?
                                 hit_value_ff : '0;
               rsp_position_in = FIELD_BITS'(lo_ff);
               rsp_count_in    = FIELD_BITS'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         cursor_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         cursor_ff    <= cursor_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_type_ff     <= req_type_in;
      key_ff          <= key_in;
      value_ff        <= value_in;
      hit_value_ff    <= hit_value_in;
      dst_ff          <= dst_in;
      status_ff       <= status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.value_out   = rsp_value_ff;
   assign rsp_bus.position    = rsp_position_ff;
   assign rsp_bus.entry_count = rsp_count_ff;

endmodule
